FILE: design/bre_pkg.sv
// Shared types and constants for the bilevel run-length line encoder.
package bre_pkg;

  localparam int unsigned RunW      = 15;
  localparam int unsigned WordW     = 16;
  localparam int unsigned WordAddrW = 24;
  localparam int unsigned ApbAddrW  = 2;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [RunW-1:0]  MaxRun    = 15'd32767;
  localparam logic [WordW-1:0] HeaderTag = 16'h5900;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned OutDepth = 16;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);

  // Configuration register byte addresses
  localparam logic [ApbAddrW-1:0] RegHeaderEnable = 2'd0;

  typedef struct packed {
    logic [7:0] pixel_bits;
    logic [3:0] bit_count;
    logic       end_of_line;
    logic       start_of_image;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]     code_word;
    logic [WordAddrW-1:0] word_address;
    logic                 last;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0] pix;
    logic [3:0] nb;
    logic       eol;
    logic       soi;
    logic       open_line;
    logic       hdr;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BITS,
    ST_ZERO,
    ST_EOL_RUN,
    ST_EOL_ZERO,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_HDR3
  } bre_state_e;

endpackage

FILE: design/bre_front.sv
// Front end: accepts input beats, classifies line opening and queues commands.
module bre_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bre_pkg::in_item_t item_i,
  output logic             full_o,
  input  logic             header_enable_i,
  output logic             cmd_valid_o,
  output bre_pkg::cmd_t    cmd_o,
  input  logic             cmd_pop_i
);
  import bre_pkg::*;

  cmd_t                cmd_q [CmdDepth];
  logic [CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CmdPtrW:0]    cnt_q, cnt_d;
  logic                line_open_q, line_open_d;
  logic                line_hdr_q, line_hdr_d;
  logic                accept;
  logic                pop;
  cmd_t                cmd_new;

  assign full_o      = (cnt_q == (CmdPtrW+1)'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign accept      = push_i && !full_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = cmd_q[rd_ptr_q];

  always_comb begin
    cmd_new.pix       = item_i.pixel_bits;
    cmd_new.nb        = (item_i.bit_count > 4'd8) ? 4'd8 : item_i.bit_count;
    cmd_new.eol       = item_i.end_of_line;
    cmd_new.soi       = item_i.start_of_image;
    cmd_new.open_line = !line_open_q || item_i.start_of_image;
    // header choice is latched when the line opens
    cmd_new.hdr       = cmd_new.open_line ? header_enable_i : line_hdr_q;
  end

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    line_open_d = line_open_q;
    line_hdr_d  = line_hdr_q;
    if (accept) begin
      wr_ptr_d    = wr_ptr_q + 1'b1;
      line_open_d = !item_i.end_of_line;
      line_hdr_d  = cmd_new.hdr;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (accept && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!accept && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      line_open_q <= 1'b0;
      line_hdr_q  <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      cnt_q       <= cnt_d;
      line_open_q <= line_open_d;
      line_hdr_q  <= line_hdr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: design/bre_back.sv
// Back end: run counting sequencer that issues run and header words.
module bre_back #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bre_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               out_full_i,
  output logic               word_push_o,
  output bre_pkg::out_item_t word_o
);
  import bre_pkg::*;

  localparam int unsigned AW = ADDRESS_BITS;

  bre_state_e        state_q, state_d, nxt;
  logic [7:0]        pix_q, pix_d;
  logic [3:0]        nb_q, nb_d;
  logic              eol_q, eol_d;
  logic              hdr_q, hdr_d;
  logic [RunW-1:0]   run_count_q, run_count_d;
  logic              pol_q, pol_d;
  logic [AW-1:0]     next_addr_q, next_addr_d;
  logic [AW-1:0]     line_start_q, line_start_d;
  logic [WordW-1:0]  line_words_q, line_words_d;
  logic [WordW-1:0]  line_ctr_q, line_ctr_d;

  logic [7:0]        xb;
  logic [7:0]        inr;
  logic [3:0]        k;
  logic              found;
  logic              quiet_after;
  logic [WordW-1:0]  sum;
  logic              ovf;
  logic [2:0]        ovf_j;
  logic              step, load, done, fin_line;
  logic              wvalid, is_run;
  logic [WordW-1:0]  wcode;
  logic [AW-1:0]     waddr;

  // Scan of the remaining pixels against the current run polarity
  always_comb begin
    found       = 1'b0;
    k           = nb_q;
    quiet_after = 1'b1;
    for (int i = 0; i < 8; i++) begin
      xb[i]  = pix_q[7-i] ^ pol_q;
      inr[i] = (4'(i) < nb_q);
    end
    for (int i = 0; i < 8; i++) begin
      if (!found && inr[i] && xb[i]) begin
        k     = 4'(i);
        found = 1'b1;
      end
    end
    // after a transition, no further change left in this beat
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) > k) && inr[i] && !xb[i]) begin
        quiet_after = 1'b0;
      end
    end
    sum   = {1'b0, run_count_q} + WordW'(k);
    ovf   = (sum > WordW'(MaxRun));
    ovf_j = 3'(MaxRun - run_count_q);
  end

  assign step      = (state_q != ST_IDLE) && !out_full_i;
  assign load      = cmd_valid_i && ((state_q == ST_IDLE) || (step && done));
  assign cmd_pop_o = load;

  // Next state
  always_comb begin
    nxt      = state_q;
    done     = 1'b0;
    fin_line = 1'b0;
    unique case (state_q)
      ST_IDLE: nxt = ST_IDLE;
      ST_BITS: begin
        if (ovf) begin
          nxt = ST_ZERO;
        end else if (found && !quiet_after) begin
          nxt = ST_BITS;
        end else if (eol_q) begin
          nxt = ST_EOL_RUN;
        end else begin
          done = 1'b1;
        end
      end
      ST_ZERO: begin
        if (found) begin
          nxt = ST_BITS;
        end else if (eol_q) begin
          nxt = ST_EOL_RUN;
        end else begin
          done = 1'b1;
        end
      end
      ST_EOL_RUN: begin
        if (pol_q) begin
          nxt = ST_EOL_ZERO;
        end else if (hdr_q) begin
          nxt = ST_HDR0;
        end else begin
          done     = 1'b1;
          fin_line = 1'b1;
        end
      end
      ST_EOL_ZERO: begin
        if (hdr_q) begin
          nxt = ST_HDR0;
        end else begin
          done     = 1'b1;
          fin_line = 1'b1;
        end
      end
      ST_HDR0: nxt = ST_HDR1;
      ST_HDR1: nxt = ST_HDR2;
      ST_HDR2: nxt = ST_HDR3;
      ST_HDR3: begin
        done     = 1'b1;
        fin_line = 1'b1;
      end
      default: nxt = ST_IDLE;
    endcase
    if (load) begin
      state_d = ST_BITS;
    end else if (step) begin
      state_d = done ? ST_IDLE : nxt;
    end else begin
      state_d = state_q;
    end
  end

  // Datapath and word output
  always_comb begin
    pix_d        = pix_q;
    nb_d         = nb_q;
    eol_d        = eol_q;
    hdr_d        = hdr_q;
    run_count_d  = run_count_q;
    pol_d        = pol_q;
    next_addr_d  = next_addr_q;
    line_start_d = line_start_q;
    line_words_d = line_words_q;
    line_ctr_d   = line_ctr_q;
    wvalid       = 1'b0;
    is_run       = 1'b0;
    wcode        = '0;
    waddr        = next_addr_q;
    if (step) begin
      unique case (state_q)
        ST_BITS: begin
          if (ovf) begin
            // run passes the limit: limit word now, then a zero word in ST_ZERO
            wvalid      = 1'b1;
            is_run      = 1'b1;
            wcode       = WordW'(MaxRun);
            run_count_d = RunW'(1);
            pix_d       = pix_q << (4'(ovf_j) + 4'd1);
            nb_d        = nb_q - (4'(ovf_j) + 4'd1);
          end else if (found) begin
            wvalid = 1'b1;
            is_run = 1'b1;
            wcode  = sum;
            pol_d  = !pol_q;
            if (quiet_after) begin
              run_count_d = RunW'(nb_q - k);
              nb_d        = '0;
            end else begin
              run_count_d = RunW'(1);
              pix_d       = pix_q << (k + 4'd1);
              nb_d        = nb_q - k - 4'd1;
            end
          end else begin
            run_count_d = sum[RunW-1:0];
            nb_d        = '0;
          end
        end
        ST_ZERO: begin
          wvalid = 1'b1;
          is_run = 1'b1;
          wcode  = '0;
          if (!found) begin
            run_count_d = run_count_q + RunW'(nb_q);
            nb_d        = '0;
          end
        end
        ST_EOL_RUN: begin
          wvalid = 1'b1;
          is_run = 1'b1;
          wcode  = {1'b0, run_count_q};
        end
        ST_EOL_ZERO: begin
          wvalid = 1'b1;
          is_run = 1'b1;
          wcode  = '0;
        end
        ST_HDR0: begin
          wvalid = 1'b1;
          wcode  = HeaderTag;
          waddr  = line_start_q;
        end
        ST_HDR1: begin
          wvalid = 1'b1;
          wcode  = line_words_q + WordW'(2);
          waddr  = line_start_q + AW'(1);
        end
        ST_HDR2: begin
          wvalid = 1'b1;
          wcode  = line_ctr_q + WordW'(1);
          waddr  = line_start_q + AW'(2);
        end
        ST_HDR3: begin
          wvalid = 1'b1;
          wcode  = '0;
          waddr  = line_start_q + AW'(3);
        end
        default: wvalid = 1'b0;
      endcase
      if (is_run) begin
        next_addr_d  = next_addr_q + AW'(1);
        line_words_d = line_words_q + WordW'(1);
      end
      if (fin_line) begin
        line_ctr_d   = line_ctr_q + WordW'(1);
        run_count_d  = '0;
        pol_d        = 1'b0;
        line_words_d = '0;
      end
    end
    if (load) begin
      if (cmd_i.soi) begin
        next_addr_d  = '0;
        line_ctr_d   = '0;
        run_count_d  = '0;
        pol_d        = 1'b0;
        line_words_d = '0;
      end
      if (cmd_i.open_line) begin
        line_start_d = next_addr_d;
        if (cmd_i.hdr) begin
          next_addr_d = next_addr_d + AW'(4);
        end
      end
      hdr_d = cmd_i.hdr;
      pix_d = cmd_i.pix;
      nb_d  = cmd_i.nb;
      eol_d = cmd_i.eol;
    end
  end

  assign word_push_o         = wvalid;
  assign word_o.code_word    = wcode;
  assign word_o.word_address = WordAddrW'(waddr);
  assign word_o.last         = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      run_count_q  <= '0;
      pol_q        <= 1'b0;
      next_addr_q  <= '0;
      line_start_q <= '0;
      line_words_q <= '0;
      line_ctr_q   <= '0;
    end else begin
      state_q      <= state_d;
      run_count_q  <= run_count_d;
      pol_q        <= pol_d;
      next_addr_q  <= next_addr_d;
      line_start_q <= line_start_d;
      line_words_q <= line_words_d;
      line_ctr_q   <= line_ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    nb_q  <= nb_d;
    eol_q <= eol_d;
    hdr_q <= hdr_d;
  end

  a_hdr_only_with_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HDR0 || state_q == ST_HDR1 || state_q == ST_HDR2 ||
     state_q == ST_HDR3) |-> hdr_q)
    else $error("header word issued on a line without header");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_push_o |-> !out_full_i)
    else $error("word pushed into full output queue");

  a_split_restarts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ZERO) |-> (run_count_q == RunW'(1)))
    else $error("split zero word without restarted run");

  a_trailing_zero_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EOL_ZERO) |-> pol_q)
    else $error("trailing zero word after an off run");

endmodule

FILE: design/bre_out_fifo.sv
// Output queue of finished code words with their addresses.
module bre_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bre_pkg::out_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bre_pkg::out_item_t data_o
);
  import bre_pkg::*;

  out_item_t           mem_q [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_q;
  logic [OutPtrW-1:0]  rd_ptr_q;
  logic [OutPtrW:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (OutPtrW+1)'(OutDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/bilevel_rle_line_encoder_unit.sv
// The back-end sequencer issues one word per cycle while the output queue is not
// full, and a beat may cause more than one word; a header is four words.
// Input queue of 2 beats and output queue of 16 words decouple both sides.
// Reset (asynchronous, active low) empties both queues, clears run, address and
// line state and clears header_enable.
module bilevel_rle_line_encoder_unit #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  bre_pkg::in_item_t             in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output bre_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bre_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bre_pkg::ApbDataW-1:0]  pwdata,
  output logic [bre_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import bre_pkg::*;

  logic      hdr_en_q;
  logic      cmd_valid;
  logic      cmd_pop;
  cmd_t      cmd;
  logic      out_full;
  logic      word_push;
  out_item_t word;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr == RegHeaderEnable)) begin
      hdr_en_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == RegHeaderEnable) begin
      prdata = ApbDataW'(hdr_en_q);
    end
  end

  bre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .item_i          (in_item_i),
    .full_o          (full),
    .header_enable_i (hdr_en_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  bre_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .word_push_o (word_push),
    .word_o      (word)
  );

  bre_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (word_push),
    .data_i  (word),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

endmodule
